>>> rtl/q12_20_round_multiply_divide_defines.svh
// assertion macros for the q12.20 multiply/divide block
`ifndef Q12_20_ROUND_MULTIPLY_DIVIDE_DEFINES_SVH
`define Q12_20_ROUND_MULTIPLY_DIVIDE_DEFINES_SVH

// implication checked every clock outside reset
`define QMD_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define QMD_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

>>> rtl/qmd_pkg.sv
package qmd_pkg;
    localparam int W = 32;
    localparam int FRAC_BITS = 20;
    localparam int NSTAGE = 20;
    localparam logic [1:0] MODE_MUL = 2'd0;
    localparam logic [1:0] MODE_DIV = 2'd1;
    localparam logic [1:0] MODE_DEC = 2'd2;
    localparam logic [31:0] BAD_VALUE = 32'hffff_ffff;
    localparam logic [31:0] RND_CARRY = 32'hffff_8000;
    localparam logic [31:0] RND_KEEP = 32'hffff_0000;
    localparam logic [31:0] RND_HALF = 32'h0000_8000;
    localparam logic [31:0] TOP_BIT = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] a;
        logic [31:0] b;
    } t_req;

    // item state carried along the chain
    typedef struct packed {
        logic [1:0]  mode;
        logic        done;
        logic [31:0] res;
        logic [31:0] x;
        logic [31:0] y;
        logic [6:0]  sh;
        logic [31:0] rem;
        logic [31:0] q;
        logic [5:0]  cnt;
    } t_cell;

    function automatic logic [5:0] f_lz(input logic [31:0] v);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) n = 6'(31 - i);
        end
        return (v == '0) ? 6'd0 : n;
    endfunction

    function automatic logic [5:0] f_tz(input logic [31:0] v);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) n = 6'(i);
        end
        return n;
    endfunction

    function automatic logic [31:0] f_round16(input logic [31:0] v);
        logic [5:0]  lz;
        logic [31:0] n;
        logic [31:0] r;
        lz = f_lz(v);
        n = v << lz;
        if ((n & RND_CARRY) == RND_CARRY) begin
            if (lz == 6'd0) r = '0;
            else r = TOP_BIT >> (lz - 6'd1);
        end else begin
            r = ((n + RND_HALF) & RND_KEEP) >> lz;
        end
        return (v == '0) ? '0 : r;
    endfunction

    // signed shift, out of range gives zero
    function automatic logic [31:0] f_shift(input logic [31:0] v, input logic signed [6:0] s);
        logic [31:0] r;
        if (s >= 7'sd32 || s <= -7'sd32) r = '0;
        else if (s > 0) r = v << s[4:0];
        else r = v >> 5'(-s);
        return r;
    endfunction
endpackage

>>> rtl/qmd_if.sv
interface qmd_if #(parameter int PW = 32);
    logic          valid;
    logic          ready;
    logic [PW-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/q12_20_round_multiply_divide.sv
// path from accepted transaction to valid result:
// two setup stages, 16 two-bit cells and the output register
// throughput: one transaction per cycle while the output register is empty or being drained
// the pipeline advances whenever the output register is empty or being drained
// reset clears the valid bits; payload registers are not reset
`include "q12_20_round_multiply_divide_defines.svh"
module q12_20_round_multiply_divide (
    input  logic i_clk,
    input  logic i_rst_n,
    qmd_if.sink   i_in,
    qmd_if.source o_out
);
    import qmd_pkg::*;
    localparam int NC = 16;
    localparam int DEPTH = NC + 3;

    t_req        req;
    t_cell       chain [NC+1];
    logic [DEPTH-1:0] r_vld;
    logic        adv;
    logic [31:0] r_res;
    logic [31:0] n_res;
    t_cell       tail;

    assign req = t_req'(i_in.data);
    assign adv = !o_out.valid || o_out.ready;
    assign i_in.ready = adv;

    qmd_prep u_prep (.i_clk(i_clk), .i_en(adv), .i_req(req), .o_cell(chain[0]));

    for (genvar g = 0; g < NC; g++) begin : g_cell
        qmd_cell u_cell (.i_clk(i_clk), .i_en(adv), .i_cell(chain[g]), .o_cell(chain[g+1]));
    end

    assign tail = chain[NC];
    always_comb begin
        if (tail.done) n_res = tail.res;
        else if (tail.mode == MODE_DIV && tail.x == '0) n_res = '0;
        else n_res = f_shift(tail.q, signed'(tail.sh));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[DEPTH-2:0], i_in.valid};
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) r_res <= n_res;
    end

    assign o_out.valid = r_vld[DEPTH-1];
    assign o_out.data = r_res;

    `QMD_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out.valid && !o_out.ready, o_out.valid)
    `QMD_ASSERT_IMP(a_ready, i_clk, i_rst_n, !o_out.valid, i_in.ready)
    `QMD_ASSERT_NEXT(a_stall, i_clk, i_rst_n, !adv, $stable(r_vld))
endmodule

>>> rtl/qmd_prep.sv
module qmd_prep (
    input  logic           i_clk,
    input  logic           i_en,
    input  qmd_pkg::t_req  i_req,
    output qmd_pkg::t_cell o_cell
);
    import qmd_pkg::*;
    t_cell       n_cell;
    t_cell       r_cell;
    t_req        r_req;
    logic [31:0] n_ra;
    logic [31:0] n_rb;
    logic [31:0] r_ra;
    logic [31:0] r_rb;
    logic [5:0]  sa;
    logic [5:0]  sb;
    logic [5:0]  sn;
    logic [31:0] dd;
    logic [31:0] cd;

    // first stage: round both operands
    always_comb begin
        n_ra = f_round16(i_req.a);
        n_rb = f_round16(i_req.b);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_req <= i_req;
            r_ra <= n_ra;
            r_rb <= n_rb;
        end
    end

    // second stage: alignment and per-mode setup
    always_comb begin
        sa = f_tz(r_ra);
        sb = f_tz(r_rb);
        sn = f_lz(r_ra);
        dd = (r_rb >> sb) & 32'h0000_ffff;
        cd = 32'((r_req.a[11:0] & 12'h0ff) | 12'h100);
        n_cell = '0;
        n_cell.mode = r_req.mode;
        case (r_req.mode)
            MODE_MUL: begin
                n_cell.x = r_ra >> sa;
                n_cell.y = r_rb >> sb;
                n_cell.sh = 7'(sa) + 7'(sb) - 7'(FRAC_BITS);
            end
            MODE_DIV: begin
                if (r_req.a == BAD_VALUE || r_req.b == BAD_VALUE || r_req.b == '0
                    || r_rb == '0 || dd == '0) begin
                    n_cell.done = 1'b1;
                    n_cell.res = BAD_VALUE;
                end
                n_cell.x = r_ra << sn;
                n_cell.y = dd;
                n_cell.sh = 7'(FRAC_BITS) - 7'(sn) - 7'(sb);
            end
            MODE_DEC: begin
                n_cell.done = 1'b1;
                n_cell.res = (r_req.a == '0) ? '0 : cd << (r_req.a[11:8] + 5'd3);
            end
            default: begin
                n_cell.done = 1'b1;
                n_cell.res = BAD_VALUE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_cell <= n_cell;
    end
    assign o_cell = r_cell;
endmodule

>>> rtl/qmd_cell.sv
module qmd_cell (
    input  logic           i_clk,
    input  logic           i_en,
    input  qmd_pkg::t_cell i_cell,
    output qmd_pkg::t_cell o_cell
);
    import qmd_pkg::*;
    t_cell       n_cell;
    t_cell       r_cell;
    logic [32:0] trial;
    logic [31:0] rem2;

    // each cell: two quotient bits, or two multiplier bits
    always_comb begin
        n_cell = i_cell;
        rem2 = i_cell.rem;
        trial = '0;
        for (int k = 0; k < 2; k++) begin
            if (i_cell.mode == MODE_MUL) begin
                if (n_cell.y[n_cell.cnt[4:0]]) n_cell.q = n_cell.q + (n_cell.x << n_cell.cnt[4:0]);
            end else begin
                trial = {rem2, n_cell.x[5'(31 - n_cell.cnt[4:0])]};
                if (trial >= 33'(n_cell.y)) begin
                    rem2 = 32'(trial - 33'(n_cell.y));
                    n_cell.q = {n_cell.q[30:0], 1'b1};
                end else begin
                    rem2 = trial[31:0];
                    n_cell.q = {n_cell.q[30:0], 1'b0};
                end
            end
            n_cell.cnt = n_cell.cnt + 6'd1;
        end
        n_cell.rem = rem2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_cell <= n_cell;
    end
    assign o_cell = r_cell;
endmodule
